FILE: hw/rtl/rme_pkg.sv
// Package with the types, constants and operand helpers of the register machine execute block.
`timescale 1ns / 1ps

package rme_pkg;

  localparam int MEM_BYTES  = 1024;
  localparam int PROG_DEPTH = 512;
  localparam int MEM_WORDS  = MEM_BYTES / 4;
  localparam int ADDR_W     = $clog2(MEM_WORDS);
  localparam int PC_W       = 9;

  typedef enum logic [4:0] {
    OP_NOP  = 5'd0,  OP_HALT = 5'd1,  OP_MOV  = 5'd2,  OP_LW   = 5'd3,
    OP_SW   = 5'd4,  OP_PUSH = 5'd5,  OP_POP  = 5'd6,  OP_PRINT = 5'd7,
    OP_READ = 5'd8,  OP_ADD  = 5'd9,  OP_SUB  = 5'd10, OP_MUL  = 5'd11,
    OP_DIV  = 5'd12, OP_CMP  = 5'd13, OP_JMP  = 5'd14, OP_JMPE = 5'd15,
    OP_JMPL = 5'd16, OP_AND  = 5'd17, OP_OR   = 5'd18, OP_XOR  = 5'd19,
    OP_LSH  = 5'd20, OP_RSH  = 5'd21
  } opcode_e;

  typedef enum logic [1:0] {
    KIND_IMM = 2'd0,
    KIND_REG = 2'd1,
    KIND_MEM = 2'd2
  } kind_e;

  typedef enum logic [3:0] {
    F_OK          = 4'd0,
    F_BAD_SRC     = 4'd1,
    F_BAD_DST     = 4'd2,
    F_MEM_RANGE   = 4'd3,
    F_BAD_KIND    = 4'd4,
    F_STACK_FULL  = 4'd5,
    F_STACK_EMPTY = 4'd6,
    F_BAD_OP      = 4'd7,
    F_DIV_ZERO    = 4'd8,
    F_BAD_TARGET  = 4'd9,
    F_STOPPED     = 4'd10
  } fault_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_DIV,
    ST_WAIT
  } state_e;

  // Register numbers as seen by the operands.
  localparam logic [2:0] REG_ZERO  = 3'd0;
  localparam logic [2:0] REG_PC    = 3'd1;
  localparam logic [2:0] REG_SP    = 3'd2;
  localparam logic [2:0] REG_FLAGS = 3'd7;

  // Allowed operand kinds, one bit per kind.
  localparam logic [2:0] KM_IMM    = 3'b001;
  localparam logic [2:0] KM_REG    = 3'b010;
  localparam logic [2:0] KM_MEM    = 3'b100;
  localparam logic [2:0] KM_ALL    = 3'b111;
  localparam logic [2:0] KM_IMMREG = 3'b011;
  localparam logic [2:0] KM_REGMEM = 3'b110;

  // Readable registers, one bit per register number.
  localparam logic [7:0] RM_ALL   = 8'hFF;
  localparam logic [7:0] RM_NO_PC = 8'hFD;
  localparam logic [7:0] RM_ALU   = 8'h7D;
  localparam logic [7:0] RM_CMP   = 8'h79;

  localparam logic [1:0] FLAG_EQ = 2'b01;
  localparam logic [1:0] FLAG_LO = 2'b10;

  typedef struct packed {
    logic [4:0]         cmd;
    logic [1:0]         src_kind;
    logic signed [31:0] src_operand;
    logic [1:0]         dst_kind;
    logic signed [31:0] dst_operand;
    logic signed [31:0] read_value;
  } instr_t;

  typedef struct packed {
    logic [PC_W-1:0]    next_pc;
    logic               halted;
    logic               print_valid;
    logic signed [31:0] print_value;
    logic [3:0]         fault;
  } result_t;

  typedef struct packed {
    logic [3:0]  fault;
    logic [31:0] value;
  } fetch_t;

  typedef struct packed {
    logic [3:0] fault;
    logic       is_mem;
  } resolve_t;

  // Reads an operand: immediate, register value or memory word.
  function automatic fetch_t fetch_op(input logic [1:0] kind, input logic [31:0] opnd,
                                      input logic [2:0] kmask, input logic [7:0] rmask,
                                      input logic [3:0] badreg, input logic [31:0] regval,
                                      input logic [31:0] memval);
    fetch_t r;
    r.fault = F_OK;
    r.value = '0;
    if (kind == 2'd3) begin
      r.fault = F_BAD_KIND;
    end else if (!kmask[kind]) begin
      r.fault = F_BAD_KIND;
    end else if (kind == KIND_IMM) begin
      r.value = opnd;
    end else if (kind == KIND_REG) begin
      if (opnd > 32'd7 || !rmask[opnd[2:0]]) begin
        r.fault = badreg;
      end else begin
        r.value = regval;
      end
    end else if (opnd >= 32'(MEM_WORDS)) begin
      r.fault = F_MEM_RANGE;
    end else begin
      r.value = memval;
    end
    return r;
  endfunction

  // Checks a destination operand: a writable register or a memory word.
  function automatic resolve_t resolve_op(input logic [1:0] kind, input logic [31:0] opnd,
                                          input logic [2:0] kmask);
    resolve_t r;
    r.fault  = F_OK;
    r.is_mem = 1'b0;
    if (kind == 2'd3) begin
      r.fault = F_BAD_KIND;
    end else if (!kmask[kind]) begin
      r.fault = F_BAD_KIND;
    end else if (kind == KIND_REG) begin
      if (opnd < 32'd3 || opnd > 32'd6) begin
        r.fault = F_BAD_DST;
      end
    end else if (opnd >= 32'(MEM_WORDS)) begin
      r.fault = F_MEM_RANGE;
    end else begin
      r.is_mem = 1'b1;
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/rme_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module rme_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hw/rtl/rme_div.sv
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
`timescale 1ns / 1ps

module rme_div
  import rme_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] quotient
);

  logic        busy;
  logic [4:0]  cnt;
  logic [31:0] quo;
  logic [31:0] divr;
  logic [31:0] rem;
  logic        neg;
  logic [32:0] rem_sh;
  logic [32:0] diff;
  logic [31:0] rem_next;
  logic [31:0] quo_next;

  always_comb begin
    rem_sh = {rem, quo[31]};
    diff   = rem_sh - {1'b0, divr};
    if (!diff[32]) begin
      rem_next = diff[31:0];
      quo_next = {quo[30:0], 1'b1};
    end else begin
      rem_next = rem_sh[31:0];
      quo_next = {quo[30:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == 5'd0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt  <= 5'd31;
      quo  <= dividend[31] ? 32'd0 - dividend : dividend;
      divr <= divisor[31] ? 32'd0 - divisor : divisor;
      rem  <= '0;
      neg  <= dividend[31] ^ divisor[31];
    end else if (busy) begin
      cnt <= cnt - 5'd1;
      quo <= quo_next;
      rem <= rem_next;
    end
  end

  // The magnitude of the most negative value is itself, which gives the wrapped result.
  assign quotient = neg ? 32'd0 - quo : quo;

endmodule

FILE: hw/rtl/register_machine_execute.sv
// Top level of the register machine execute block.
`timescale 1ns / 1ps

// Executes one decoded instruction per input transfer on a small two-operand
// machine and returns one result transfer per instruction.
// The instr channel carries the decoded instruction; the result channel carries
// the next program counter with halt, print and fault status.
// The word memory read is registered at the instruction's transfer; the execute
// state then performs the operation and writes back, and the wait state loads
// the output register. Division passes through the divide state while the
// bit-serial divider works, and its result is written back when it is done.
// The next instruction is taken once the current one has reached the output
// stage, so a new instruction may enter while a finished result waits.
// After reset the data memory is cleared one word per cycle, all 256 words;
// instr_stall stays high during that sweep.
// When the receiver stalls, the result stays in the output register and the
// following result waits in the wait state, which then holds off new
// instructions.
// After a halt or a fault every instruction returns the stopped fault until reset.
module register_machine_execute
  import rme_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    instr_valid,
  output logic    instr_stall,
  input  instr_t  instr,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  state_e state;
  state_e state_next;

  instr_t          item;
  logic [31:0]     gr [4];
  logic [PC_W-1:0] pc;
  logic [31:0]     sp;
  logic [1:0]      flags;
  logic            stopped;
  logic [ADDR_W-1:0] clr_cnt;
  result_t         res;
  logic [1:0]      div_sel;
  logic [PC_W-1:0] div_pc;

  logic              accept;
  logic              out_load;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [31:0]       ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [31:0]       rdata;

  logic        div_start;
  logic        div_done;
  logic [31:0] div_q;

  logic [31:0] src_reg;
  logic [31:0] dst_reg;
  fetch_t      sf;
  fetch_t      df;
  resolve_t    rs;
  logic [3:0]  f;
  logic        halt;
  logic        pvalid;
  logic [31:0] pval;
  logic [PC_W-1:0] pc_seq;
  logic [PC_W-1:0] pc_new;
  logic        gr_we;
  logic [1:0]  gr_sel;
  logic [31:0] gr_val;
  logic        mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [31:0] mem_wdata;
  logic        sp_we;
  logic [31:0] sp_new;
  logic        flags_we;
  logic [1:0]  flags_val;
  logic        div_go;
  logic [31:0] sp_dec;
  logic [1:0]  ssel;
  logic [1:0]  dsel;

  assign accept = instr_valid && !instr_stall;

  // Pop reads at the stack pointer, everything else at the first operand's word index.
  assign ram_raddr = (instr.cmd == OP_POP) ? sp[ADDR_W+1:2] : instr.src_operand[ADDR_W-1:0];

  always_comb begin
    if (state == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt;
      ram_wdata = '0;
    end else begin
      ram_we    = mem_we && state == ST_EXEC;
      ram_waddr = mem_waddr;
      ram_wdata = mem_wdata;
    end
  end

  rme_ram #(
    .WIDTH(32),
    .DEPTH(MEM_WORDS)
  ) u_mem (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (accept),
    .raddr(ram_raddr),
    .rdata(rdata)
  );

  rme_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(dst_reg),
    .divisor (sf.value),
    .done    (div_done),
    .quotient(div_q)
  );

  always_comb begin
    unique case (item.src_operand[2:0])
      REG_ZERO:  src_reg = '0;
      REG_PC:    src_reg = 32'(pc);
      REG_SP:    src_reg = sp;
      REG_FLAGS: src_reg = 32'(flags);
      default:   src_reg = gr[2'(item.src_operand[2:0] - 3'd3)];
    endcase
    unique case (item.dst_operand[2:0])
      REG_ZERO:  dst_reg = '0;
      REG_PC:    dst_reg = 32'(pc);
      REG_SP:    dst_reg = sp;
      REG_FLAGS: dst_reg = 32'(flags);
      default:   dst_reg = gr[2'(item.dst_operand[2:0] - 3'd3)];
    endcase
  end

  assign ssel   = 2'(item.src_operand[2:0] - 3'd3);
  assign dsel   = 2'(item.dst_operand[2:0] - 3'd3);
  assign sp_dec = sp - 32'd4;
  assign pc_seq = (pc == PC_W'(PROG_DEPTH - 1)) ? '0 : pc + 1'b1;

  // Execute stage: operand checks, the operation and the write-back requests.
  always_comb begin
    sf        = fetch_op(item.src_kind, item.src_operand, KM_ALL, RM_NO_PC, F_BAD_SRC,
                         src_reg, rdata);
    df        = '0;
    rs        = resolve_op(item.dst_kind, item.dst_operand, KM_REGMEM);
    f         = F_OK;
    halt      = 1'b0;
    pvalid    = 1'b0;
    pval      = '0;
    pc_new    = pc_seq;
    gr_we     = 1'b0;
    gr_sel    = dsel;
    gr_val    = sf.value;
    mem_we    = 1'b0;
    mem_waddr = item.dst_operand[ADDR_W-1:0];
    mem_wdata = sf.value;
    sp_we     = 1'b0;
    sp_new    = sp;
    flags_we  = 1'b0;
    flags_val = '0;
    div_go    = 1'b0;
    if (stopped) begin
      f = F_STOPPED;
    end else begin
      unique case (item.cmd)
        OP_NOP: begin
        end
        OP_HALT: halt = 1'b1;
        OP_MOV, OP_LW, OP_SW: begin
          sf = fetch_op(item.src_kind, item.src_operand,
                        (item.cmd == OP_LW) ? KM_MEM : KM_ALL, RM_NO_PC, F_BAD_SRC,
                        src_reg, rdata);
          rs = resolve_op(item.dst_kind, item.dst_operand,
                          (item.cmd == OP_SW) ? KM_MEM : KM_REGMEM);
          f  = (sf.fault != F_OK) ? sf.fault : rs.fault;
          if (f == F_OK) begin
            mem_we = rs.is_mem;
            gr_we  = !rs.is_mem;
          end
        end
        OP_PUSH: begin
          if (sf.fault != F_OK) begin
            f = sf.fault;
          end else if (sp[31] || sp == '0) begin
            f = F_STACK_FULL;
          end else begin
            sp_we     = 1'b1;
            sp_new    = sp_dec;
            mem_we    = 1'b1;
            mem_waddr = sp_dec[ADDR_W+1:2];
          end
        end
        OP_POP: begin
          rs = resolve_op(item.src_kind, item.src_operand, KM_REGMEM);
          if (!sp[31] && sp >= 32'(MEM_BYTES)) begin
            f = F_STACK_EMPTY;
          end else begin
            f = rs.fault;
          end
          if (f == F_OK) begin
            sp_we     = 1'b1;
            sp_new    = sp + 32'd4;
            mem_we    = rs.is_mem;
            gr_we     = !rs.is_mem;
            mem_waddr = item.src_operand[ADDR_W-1:0];
            mem_wdata = rdata;
            gr_sel    = ssel;
            gr_val    = rdata;
          end
        end
        OP_PRINT: begin
          sf = fetch_op(item.src_kind, item.src_operand, KM_ALL, RM_ALL, F_BAD_SRC,
                        src_reg, rdata);
          f  = sf.fault;
          if (f == F_OK) begin
            pvalid = 1'b1;
            pval   = sf.value;
          end
        end
        OP_READ: begin
          rs = resolve_op(item.src_kind, item.src_operand, KM_REG);
          f  = rs.fault;
          if (f == F_OK) begin
            gr_we  = 1'b1;
            gr_sel = ssel;
            gr_val = item.read_value;
          end
        end
        OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_AND, OP_OR, OP_XOR, OP_LSH, OP_RSH: begin
          sf = fetch_op(item.src_kind, item.src_operand, KM_IMMREG, RM_ALU, F_BAD_SRC,
                        src_reg, rdata);
          rs = resolve_op(item.dst_kind, item.dst_operand, KM_REG);
          f  = (sf.fault != F_OK) ? sf.fault : rs.fault;
          if (f == F_OK) begin
            gr_we = 1'b1;
            unique case (item.cmd)
              OP_ADD: gr_val = dst_reg + sf.value;
              OP_SUB: gr_val = dst_reg - sf.value;
              OP_MUL: gr_val = dst_reg * sf.value;
              OP_AND: gr_val = dst_reg & sf.value;
              OP_OR:  gr_val = dst_reg | sf.value;
              OP_XOR: gr_val = dst_reg ^ sf.value;
              OP_LSH: gr_val = (sf.value >= 32'd32) ? '0 : dst_reg << sf.value[4:0];
              OP_RSH: gr_val = (sf.value >= 32'd32) ? {32{dst_reg[31]}}
                             : 32'($signed(dst_reg) >>> sf.value[4:0]);
              default: begin
                gr_we = 1'b0;
                if (sf.value == '0) begin
                  f = F_DIV_ZERO;
                end else begin
                  div_go = 1'b1;
                end
              end
            endcase
          end
        end
        OP_CMP: begin
          sf = fetch_op(item.src_kind, item.src_operand, KM_IMMREG, RM_CMP, F_BAD_SRC,
                        src_reg, rdata);
          df = fetch_op(item.dst_kind, item.dst_operand, KM_IMMREG, RM_CMP, F_BAD_DST,
                        dst_reg, rdata);
          f  = (sf.fault != F_OK) ? sf.fault : df.fault;
          if (f == F_OK) begin
            flags_we = 1'b1;
            if (df.value == sf.value) begin
              flags_val = FLAG_EQ;
            end else if ($signed(df.value) > $signed(sf.value)) begin
              flags_val = FLAG_LO;
            end
          end
        end
        OP_JMP, OP_JMPE, OP_JMPL: begin
          if (item.cmd == OP_JMP || (item.cmd == OP_JMPE && flags[0]) ||
              (item.cmd == OP_JMPL && flags[1])) begin
            if (item.src_operand >= 32'(PROG_DEPTH) || item.src_operand < 0) begin
              f = F_BAD_TARGET;
            end else begin
              pc_new = item.src_operand[PC_W-1:0];
            end
          end
        end
        default: f = F_BAD_OP;
      endcase
    end
  end

  assign div_start = (state == ST_EXEC) && div_go;
  assign out_load  = (state == ST_WAIT) && (!result_valid || !result_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    instr_stall = 1'b1;
    unique case (state)
      ST_CLEAR: begin
        if (clr_cnt == ADDR_W'(MEM_WORDS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        instr_stall = 1'b0;
        if (instr_valid) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: state_next = div_go ? ST_DIV : ST_WAIT;
      ST_DIV: begin
        if (div_done) begin
          state_next = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  // Architectural state and the memory clear counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) begin
        gr[i] <= '0;
      end
      pc      <= '0;
      sp      <= 32'(MEM_BYTES);
      flags   <= '0;
      stopped <= 1'b0;
      clr_cnt <= '0;
    end else begin
      if (state == ST_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (state == ST_EXEC) begin
        if (f != F_OK || halt) begin
          stopped <= 1'b1;
        end else if (!div_go) begin
          pc <= pc_new;
          if (gr_we) begin
            gr[gr_sel] <= gr_val;
          end
          if (sp_we) begin
            sp <= sp_new;
          end
          if (flags_we) begin
            flags <= flags_val;
          end
        end
      end
      if (state == ST_DIV && div_done) begin
        gr[div_sel] <= div_q;
        pc          <= div_pc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= instr;
    end
    if (state == ST_EXEC) begin
      div_sel         <= dsel;
      div_pc          <= pc_new;
      res.halted      <= (f != F_OK) || halt;
      res.fault       <= f;
      res.print_valid <= pvalid && f == F_OK && !halt;
      res.print_value <= (pvalid && f == F_OK && !halt) ? pval : '0;
      res.next_pc     <= (f != F_OK || halt) ? pc : pc_new;
    end
    if (state == ST_DIV && div_done) begin
      res.next_pc <= div_pc;
    end
    if (out_load) begin
      result <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

endmodule

FILE: hw/rtl/rme_checker.sv
// Port-level checker for the register machine execute block, bound to the top level.
`timescale 1ns / 1ps

module rme_checker
  import rme_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    instr_valid,
  input logic    instr_stall,
  input instr_t  instr,
  input logic    result_valid,
  input logic    result_stall,
  input result_t result
);

  // A stalled result holds until its transfer.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("result changed while stalled");

  // The memory sweep after reset keeps the instruction channel closed.
  a_reset_stall: assert property (@(posedge clk) rst |=> instr_stall)
    else $error("instruction taken right after reset");

  a_fault_halts: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.fault != F_OK |-> result.halted)
    else $error("fault reported without halt");

  a_print_clean: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.print_valid |-> result.fault == F_OK && !result.halted)
    else $error("print reported together with a stop");

  a_print_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.print_valid |-> result.print_value == '0)
    else $error("print value set without print");

endmodule

bind register_machine_execute rme_checker u_rme_checker (.*);
